// ===== sv/sconv_pkg.sv =====
// Package: shared constants, types and arithmetic helpers for the separable convolver.
`default_nettype none
package sconv_pkg;
	localparam int unsigned MaxTaps   = 8;
	localparam int unsigned MaxHeight = 1024;
	localparam int unsigned MaxWidth  = 1024;
	localparam int unsigned PixW      = 24;
	localparam int unsigned CoefW     = 16;
	localparam int unsigned CfgW      = 64;
	localparam int unsigned AccW      = 48;

	typedef enum logic [2:0] {
		REG_COL_LO  = 3'd0,
		REG_COL_HI  = 3'd1,
		REG_ROW_LO  = 3'd2,
		REG_ROW_HI  = 3'd3,
		REG_COL_TAP = 3'd4,
		REG_ROW_TAP = 3'd5,
		REG_HEIGHT  = 3'd6,
		REG_WIDTH   = 3'd7
	} reg_idx_t;

	// round half up by 2^13, shift by 14, saturate to 24-bit signed
	function automatic logic signed [PixW-1:0] round_sat(input logic signed [AccW-1:0] acc);
		logic signed [AccW-1:0] v;
		logic signed [AccW-15:0] q;
		v = acc + AccW'(8192);
		q = v[AccW-1:14];
		if (q > $signed((AccW-14)'(8388607)))
			round_sat = 24'sh7FFFFF;
		else if (q < -$signed((AccW-14)'(8388608)))
			round_sat = 24'sh800000;
		else
			round_sat = q[PixW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== sv/separable_conv2d_valid.sv =====
// Top level: streaming separable 2D convolution over the valid region.
`default_nettype none
// One pixel word is accepted per clock, column-major. Column results are kept
// in a dual-port column store of MAX_TAPS columns x MAX_HEIGHT rows; the row
// pass reads all MAX_TAPS slots of the current row in parallel (one banked
// synchronous memory per slot), so the sustained rate is one word per clock,
// limited only by output backpressure. Store entries are undefined until
// written; no clearing pass is needed.
module separable_conv2d_valid
	import sconv_pkg::*;
#(
	parameter int unsigned MAX_TAPS   = MaxTaps,
	parameter int unsigned MAX_HEIGHT = MaxHeight,
	parameter int unsigned MAX_WIDTH  = MaxWidth
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [CfgW-1:0]        cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [PixW-1:0] pixel,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [PixW-1:0]      filtered,
	output logic [9:0]                  out_row,
	output logic [9:0]                  out_col,
	output logic                        last_pixel
);
	localparam int unsigned TW = $clog2(MAX_TAPS + 1);
	localparam int unsigned SW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int unsigned YW = $clog2(MAX_HEIGHT);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

	logic [CfgW-1:0] col_lo_q, col_hi_q, row_lo_q, row_hi_q;
	logic [3:0]      col_taps_q, row_taps_q;
	logic [10:0]     height_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_lo_q <= '0; col_hi_q <= '0; row_lo_q <= '0; row_hi_q <= '0;
			col_taps_q <= 4'd1; row_taps_q <= 4'd1;
			height_q <= 11'd1024; width_q <= 11'd1024;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COL_LO:  col_lo_q <= cfg_data;
				REG_COL_HI:  col_hi_q <= cfg_data;
				REG_ROW_LO:  row_lo_q <= cfg_data;
				REG_ROW_HI:  row_hi_q <= cfg_data;
				REG_COL_TAP: col_taps_q <= cfg_data[3:0];
				REG_ROW_TAP: row_taps_q <= cfg_data[3:0];
				REG_HEIGHT:  height_q <= cfg_data[10:0];
				REG_WIDTH:   width_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// clamped configuration
	logic [TW-1:0] kc, kr;
	logic [HW-1:0] h;
	logic [WW-1:0] w;
	always_comb begin
		if (col_taps_q == 4'd0) kc = TW'(1);
		else if (32'(col_taps_q) > MAX_TAPS) kc = TW'(MAX_TAPS);
		else kc = TW'(col_taps_q);
		if (row_taps_q == 4'd0) kr = TW'(1);
		else if (32'(row_taps_q) > MAX_TAPS) kr = TW'(MAX_TAPS);
		else kr = TW'(row_taps_q);
		if (height_q == 11'd0) h = HW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
		else h = HW'(height_q);
		if (width_q == 11'd0) w = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) w = WW'(MAX_WIDTH);
		else w = WW'(width_q);
	end

	function automatic logic signed [CoefW-1:0] coef(input logic [CfgW-1:0] lo,
		input logic [CfgW-1:0] hi, input int unsigned k);
		logic [CfgW-1:0] wd;
		wd = (k < 4) ? lo : hi;
		coef = wd[16*(k%4) +: 16];
	endfunction

	// pipeline control: s1 column MAC, s2 store write/read, s3 row MAC, output reg
	logic adv;
	logic v_s1, v_s2, v_s3;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	logic acc_in;
	assign acc_in = in_valid && in_ready;

	logic signed [PixW-1:0] win_q [MAX_TAPS];
	logic [HW-1:0] y_q;
	logic [WW-1:0] x_q;
	logic [SW-1:0] slot_q;

	logic col_ok, row_ok;
	assign col_ok = (32'(y_q) < 32'(h)) && (32'(x_q) < 32'(w)) && (32'(kc) <= 32'(h))
		&& (32'(kr) <= 32'(w)) && (32'(y_q) + 1 >= 32'(kc));
	assign row_ok = 32'(x_q) + 1 >= 32'(kr);

	// column MAC on the shifted window
	logic signed [AccW-1:0] cacc;
	always_comb begin
		cacc = '0;
		for (int unsigned j = 0; j < MAX_TAPS; j++) begin
			if (j == 0) begin
				if (32'(kc) > j) cacc += AccW'(coef(col_lo_q, col_hi_q, j) * pixel);
			end else if (32'(kc) > j) begin
				cacc += AccW'(coef(col_lo_q, col_hi_q, j) * win_q[j-1]);
			end
		end
	end

	logic signed [PixW-1:0] t_s1;
	logic [YW-1:0] yp_s1, yp_s2;
	logic [SW-1:0] slot_s1, slot_s2;
	logic rv_s1, rv_s2;
	logic [9:0] orow_s1, ocol_s1, orow_s2, ocol_s2, orow_s3, ocol_s3;
	logic last_s1, last_s2, last_s3;
	logic [TW-1:0] kr_s1, kr_s2;

	// slot_q follows x_q modulo MAX_TAPS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned j = 0; j < MAX_TAPS; j++) win_q[j] <= '0;
			y_q <= '0; x_q <= '0; slot_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_in && col_ok;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && rv_s2;
			if (acc_in) begin
				win_q[0] <= pixel;
				for (int unsigned j = 1; j < MAX_TAPS; j++) win_q[j] <= win_q[j-1];
				if (32'(y_q) + 1 >= 32'(h)) begin
					y_q <= '0;
					if (32'(x_q) + 1 >= 32'(w)) begin
						x_q <= '0;
						slot_q <= '0;
					end else begin
						x_q <= x_q + 1'b1;
						slot_q <= (slot_q == SW'(MAX_TAPS - 1)) ? '0 : slot_q + 1'b1;
					end
				end else begin
					y_q <= y_q + 1'b1;
					if (32'(x_q) >= 32'(w)) begin
						x_q <= '0;
						slot_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= round_sat(cacc);
			yp_s1 <= YW'(32'(y_q) + 1 - 32'(kc));
			slot_s1 <= slot_q;
			rv_s1 <= row_ok;
			kr_s1 <= kr;
			orow_s1 <= 10'(32'(y_q) + 1 - 32'(kc));
			ocol_s1 <= 10'(32'(x_q) + 1 - 32'(kr));
			last_s1 <= (32'(y_q) + 1 == 32'(h)) && (32'(x_q) + 1 == 32'(w));
			yp_s2 <= yp_s1; slot_s2 <= slot_s1; rv_s2 <= rv_s1; kr_s2 <= kr_s1;
			orow_s2 <= orow_s1; ocol_s2 <= ocol_s1; last_s2 <= last_s1;
			orow_s3 <= orow_s2; ocol_s3 <= ocol_s2; last_s3 <= last_s2;
		end
	end

	// column store: one bank per slot, written in s1->s2, read in s1 (registered)
	logic signed [PixW-1:0] mem [MAX_TAPS][MAX_HEIGHT];
	logic signed [PixW-1:0] rd_s2 [MAX_TAPS];
	logic signed [PixW-1:0] t_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= t_s1;
			for (int unsigned b = 0; b < MAX_TAPS; b++) begin
				rd_s2[b] <= mem[b][yp_s1];
				if (v_s1 && slot_s1 == SW'(b)) mem[b][yp_s1] <= t_s1;
			end
		end
	end

	// row MAC: tap j reads slot (slot - j); tap 0 is the freshly computed value
	logic signed [AccW-1:0] racc;
	always_comb begin
		logic [SW-1:0] rs;
		racc = '0;
		rs = '0;
		for (int unsigned j = 0; j < MAX_TAPS; j++) begin
			if (32'(kr_s2) > j) begin
				if (j == 0) begin
					racc += AccW'(coef(row_lo_q, row_hi_q, j) * t_s2);
				end else begin
					rs = (slot_s2 >= SW'(j)) ? slot_s2 - SW'(j)
						: slot_s2 + SW'(MAX_TAPS - j);
					racc += AccW'(coef(row_lo_q, row_hi_q, j) * rd_s2[rs]);
				end
			end
		end
	end

	logic signed [PixW-1:0] r_s3;
	always_ff @(posedge clk) begin
		if (adv) r_s3 <= round_sat(racc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			filtered <= r_s3; out_row <= orow_s3; out_col <= ocol_s3;
			last_pixel <= last_s3;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered))
		else $error("output word changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_s3))
		else $error("pipeline moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
endmodule
`default_nettype wire
